// File: design/smao_pkg.sv
// Shared constants and types for the stack machine ALU block.
package smao_pkg;

	localparam int WORD_W          = 32;
	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEPTH_W         = 7;
	localparam int MODE_W          = 3;

	localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SWAP = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NOP  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SUB  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DIV  = 3'd5;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	localparam int DIV_CNT_W = $clog2(WORD_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

endpackage

// File: design/smao_ifs.sv
// Valid/ready channel interfaces for the command and response beats.
interface smao_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [smao_pkg::MODE_W-1:0] mode;
	logic signed [smao_pkg::WORD_W-1:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface smao_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic signed [smao_pkg::WORD_W-1:0]  top_value;
	logic [smao_pkg::DEPTH_W-1:0]        stack_depth;

	modport source (output valid, output status, output top_value, output stack_depth,
		input ready);
	modport sink   (input valid, input status, input top_value, input stack_depth,
		output ready);
endinterface

// File: design/stack_machine_alu_ops_top.sv
// Bounded data stack of 32-bit words with push, swap, add, sub, div and nop; one
// response beat per command beat. The top word sits in a register and the words
// below it in a single-port synchronous memory. A command is taken in S_IDLE
// (memory read of the second word) and push, swap, add, sub, nop and every
// error finish in S_EXEC, which waits while the response register is full.
// Div runs a radix-2 restoring divider in S_DIV, one quotient bit a cycle, and
// finishes in S_FIN. A new command is taken only after the previous one has been
// handed to the response register, which may wait for its beat to be taken.
module stack_machine_alu_ops_top #(
	parameter int STACK_DEPTH = smao_pkg::DEF_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	smao_cmd_if.sink    cmd,
	smao_rsp_if.source  rsp
);
	import smao_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_FIN} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [WORD_W-1:0]     top_q;
	logic [MODE_W-1:0]     op_q;
	logic [WORD_W-1:0]     word_q;
	logic [WORD_W-1:0]     rd_q;

	logic [WORD_W-1:0]     stack_mem [STACK_DEPTH];

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [WORD_W-1:0]     out_top_q;
	logic [DEPTH_W-1:0]    out_depth_q;

	logic [WORD_W-1:0]     rem_q, quo_q, dvs_q;
	logic                  neg_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;

	logic                  cmd_acc, out_free, out_load;
	logic [CW-1:0]         cnt_m1, cnt_m2;
	logic                  is_full, is_short;

	status_t               ex_status;
	logic [CW-1:0]         ex_count;
	logic [WORD_W-1:0]     ex_top;
	logic                  ex_wr, ex_div;
	logic [AW-1:0]         ex_waddr;
	logic                  mem_we;

	logic [WORD_W:0]       div_shift, div_diff;
	logic                  div_take;
	logic [WORD_W-1:0]     div_res, s_mag, t_mag;

	status_t               res_status;
	logic [CW-1:0]         res_count;
	logic [WORD_W-1:0]     res_top;
	logic [CW+DEPTH_W-1:0] depth_ext;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = out_free && ((state_q == S_EXEC && !ex_div) || state_q == S_FIN);

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.top_value   = out_top_q;
	assign rsp.stack_depth = out_depth_q;

	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign is_full  = (count_q == CW'(STACK_DEPTH));
	assign is_short = (count_q < CW'(2));

	// execute step: second word arrives in rd_q
	always_comb begin
		ex_status = ST_OK;
		ex_count  = count_q;
		ex_top    = top_q;
		ex_wr     = 1'b0;
		ex_div    = 1'b0;
		ex_waddr  = cnt_m2[AW-1:0];
		unique case (op_q) inside
			MODE_PUSH: begin
				if (is_full) begin
					ex_status = ST_FULL;
				end else begin
					// spill the old top below the new one
					ex_wr    = (count_q != '0);
					ex_waddr = cnt_m1[AW-1:0];
					ex_top   = word_q;
					ex_count = count_q + CW'(1);
				end
			end
			MODE_SWAP, MODE_ADD, MODE_SUB, MODE_DIV: begin
				if (is_short) begin
					ex_status = ST_SHORT;
				end else if (op_q == MODE_SWAP) begin
					ex_wr  = 1'b1;
					ex_top = rd_q;
				end else if (op_q == MODE_ADD) begin
					ex_top   = rd_q + top_q;
					ex_count = cnt_m1;
				end else if (op_q == MODE_SUB) begin
					ex_top   = rd_q - top_q;
					ex_count = cnt_m1;
				end else if (top_q == '0) begin
					ex_status = ST_DIVZERO;
				end else begin
					ex_div = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_mag = rd_q[WORD_W-1] ? (~rd_q + WORD_W'(1)) : rd_q;
	assign t_mag = top_q[WORD_W-1] ? (~top_q + WORD_W'(1)) : top_q;

	assign div_shift = {rem_q, quo_q[WORD_W-1]};
	assign div_diff  = div_shift - {1'b0, dvs_q};
	assign div_take  = !div_diff[WORD_W];
	assign div_res   = neg_q ? (~quo_q + WORD_W'(1)) : quo_q;

	always_comb begin
		if (state_q == S_FIN) begin
			res_status = ST_OK;
			res_count  = cnt_m1;
			res_top    = div_res;
		end else begin
			res_status = ex_status;
			res_count  = ex_count;
			res_top    = (ex_count == '0) ? '0 : ex_top;
		end
	end

	assign depth_ext = {{DEPTH_W{1'b0}}, res_count};
	assign mem_we    = (state_q == S_EXEC) && out_free && ex_wr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[ex_waddr] <= top_q;
		end
		if (cmd_acc) begin
			rd_q <= stack_mem[cnt_m2[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						op_q    <= cmd.mode;
						word_q  <= cmd.push_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ex_div) begin
						rem_q     <= '0;
						quo_q     <= s_mag;
						dvs_q     <= t_mag;
						neg_q     <= rd_q[WORD_W-1] ^ top_q[WORD_W-1];
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end else if (out_free) begin
						top_q        <= ex_top;
						count_q      <= res_count;
						out_status_q <= res_status;
						out_top_q    <= res_top;
						out_depth_q  <= depth_ext[DEPTH_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				S_DIV: begin
					rem_q     <= div_take ? div_diff[WORD_W-1:0] : div_shift[WORD_W-1:0];
					quo_q     <= {quo_q[WORD_W-2:0], div_take};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold the quotient until the response register frees up
					if (out_free) begin
						top_q        <= res_top;
						count_q      <= res_count;
						out_status_q <= res_status;
						out_top_q    <= res_top;
						out_depth_q  <= depth_ext[DEPTH_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd.ready)
		else $error("command taken while previous one in flight");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (dvs_q != '0))
		else $error("divider running with zero divisor");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		($past(state_q) == S_EXEC || $past(state_q) == S_FIN))
		else $error("stack count changed outside completion");
`endif

endmodule
